// ----- design/tsm_pkg.sv -----
// Shared types and constants for the two-wire sensor measurement master.
package tsm_pkg;

  // Clock cells sent with data released before the start pattern of a link reset
  localparam logic [3:0] RESET_CLOCKS = 4'd9;

  // Start pattern, one bit per slot, slot 0 in bit 0
  localparam logic [6:0] START_SCK = 7'b0110110;
  localparam logic [6:0] START_DAT = 7'b1100011;
  localparam logic [2:0] START_LAST = 3'd6;

  // Bits in one byte on the wire
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Register reset values
  localparam logic [23:0] WAIT_LIMIT_RESET   = 24'd100000;
  localparam logic [7:0]  SETTLE_TICKS_RESET = 8'd50;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_WAIT_LIMIT   = 1'b0,
    REG_SETTLE_TICKS = 1'b1
  } reg_index_t;

  // Operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RSTCLK  = 4'd1,
    PH_START_R = 4'd2,
    PH_START_M = 4'd3,
    PH_WRBIT   = 4'd4,
    PH_WRACK   = 4'd5,
    PH_SETTLE  = 4'd6,
    PH_POLL    = 4'd7,
    PH_RDBIT   = 4'd8,
    PH_RDACK   = 4'd9
  } phase_t;

  // One slot request
  typedef struct packed {
    logic       start_req;
    logic       operation;
    logic [7:0] command;
    logic       data_in;
  } in_item_t;

  // One slot result
  typedef struct packed {
    logic        sck;
    logic        data_out;
    logic        busy_res;
    logic        done_res;
    logic        error;
    logic [15:0] value;
    logic [7:0]  checksum;
  } out_item_t;

endpackage

// ----- design/tsm_if.sv -----
// Slot channels: request in, pin levels and status out.
interface tsm_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       operation;
  logic [7:0] command;
  logic       data_in;

  modport source (output valid, output start_req, output operation, output command,
                  output data_in, input ready);
  modport sink   (input valid, input start_req, input operation, input command,
                  input data_in, output ready);
endinterface

interface tsm_out_if;
  logic        valid;
  logic        ready;
  logic        sck;
  logic        data_out;
  logic        busy_res;
  logic        done_res;
  logic        error;
  logic [15:0] value;
  logic [7:0]  checksum;

  modport source (output valid, output sck, output data_out, output busy_res,
                  output done_res, output error, output value, output checksum,
                  input ready);
  modport sink   (input valid, input sck, input data_out, input busy_res,
                  input done_res, input error, input value, input checksum,
                  output ready);
endinterface

// ----- design/two_wire_sensor_measure_master.sv -----
// The result of a slot transaction is registered and offered in the cycle after it is accepted.
// Throughput: one slot per cycle while pins_out.ready holds; the result register frees
// as it is taken, so a new slot is accepted in the same cycle the previous result leaves.
// Reset (rst, synchronous): link idle with the clock line high, no result pending,
// wait_limit 100000 and settle_ticks 50.
module two_wire_sensor_measure_master (
  input  logic        clk,
  input  logic        rst,
  tsm_in_if.sink      slot_in,
  tsm_out_if.source   pins_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsm_pkg::*;

  logic [23:0] wait_limit;
  logic [7:0]  settle_ticks;
  logic        advance;
  logic        out_valid;
  in_item_t    item;
  out_item_t   result;
  out_item_t   out_reg;
  reg_index_t  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit   <= WAIT_LIMIT_RESET;
      settle_ticks <= SETTLE_TICKS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WAIT_LIMIT:   wait_limit   <= pwdata[23:0];
        REG_SETTLE_TICKS: settle_ticks <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_WAIT_LIMIT:   prdata = {8'd0, wait_limit};
      REG_SETTLE_TICKS: prdata = {24'd0, settle_ticks};
      default:          prdata = '0;
    endcase
  end

  // Accept a slot whenever the result register is free or being emptied
  assign slot_in.ready = !out_valid || pins_out.ready;
  assign advance       = slot_in.valid && slot_in.ready;

  assign item.start_req = slot_in.start_req;
  assign item.operation = slot_in.operation;
  assign item.command   = slot_in.command;
  assign item.data_in   = slot_in.data_in;

  tsm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .wait_limit   (wait_limit),
    .settle_ticks (settle_ticks),
    .result       (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pins_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign pins_out.valid    = out_valid;
  assign pins_out.sck      = out_reg.sck;
  assign pins_out.data_out = out_reg.data_out;
  assign pins_out.busy_res = out_reg.busy_res;
  assign pins_out.done_res = out_reg.done_res;
  assign pins_out.error    = out_reg.error;
  assign pins_out.value    = out_reg.value;
  assign pins_out.checksum = out_reg.checksum;

endmodule

// ----- design/tsm_core.sv -----
// Slot sequencer: link state, next-state logic and the pin levels for one slot.
module tsm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tsm_pkg::in_item_t  item,
  input  logic [23:0]        wait_limit,
  input  logic [7:0]         settle_ticks,
  output tsm_pkg::out_item_t result
);
  import tsm_pkg::*;

  phase_t      phase,          phase_next;
  logic [3:0]  bit_count,      bit_count_next;
  logic [1:0]  byte_count,     byte_count_next;
  logic [7:0]  shift_reg,      shift_reg_next;
  logic [15:0] captured_word,  captured_word_next;
  logic [7:0]  captured_check, captured_check_next;
  logic [23:0] wait_count,     wait_count_next;
  logic        clock_level,    clock_level_next;

  logic [23:0] limit;
  logic [2:0]  start_idx;
  logic [3:0]  bit_inc;
  logic [23:0] wait_inc;
  logic        good;

  assign limit = (wait_limit == '0) ? 24'd1 : wait_limit;

  // Work out one slot, in the order the link protocol takes it
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    byte_count_next     = byte_count;
    shift_reg_next      = shift_reg;
    captured_word_next  = captured_word;
    captured_check_next = captured_check;
    wait_count_next     = wait_count;
    clock_level_next    = clock_level;
    good                = 1'b0;
    start_idx           = '0;
    bit_inc             = '0;
    wait_inc            = '0;
    result              = '0;
    result.data_out     = 1'b1;
    result.busy_res     = 1'b1;

    if (phase == PH_IDLE && !item.start_req) begin
      // Idle slot: hold the last clock level, release data
      result.sck      = clock_level;
      result.busy_res = 1'b0;
    end else begin
      // Take a new request
      if (phase == PH_IDLE) begin
        bit_count_next   = '0;
        byte_count_next  = '0;
        wait_count_next  = '0;
        clock_level_next = 1'b0;
        if (item.operation == OP_RESET) begin
          phase_next = PH_RSTCLK;
        end else begin
          phase_next     = PH_START_M;
          shift_reg_next = item.command;
        end
      end

      // Settling delay after the command ack
      if (phase_next == PH_SETTLE) begin
        if (wait_count_next >= {16'd0, settle_ticks}) begin
          phase_next      = PH_POLL;
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_count_next + 24'd1;
        end
      end

      bit_inc  = bit_count_next + 4'd1;
      wait_inc = wait_count_next + 24'd1;

      unique case (phase_next)
        PH_RSTCLK: begin
          if (!clock_level_next) begin
            result.sck       = 1'b1;
            clock_level_next = 1'b1;
          end else begin
            clock_level_next = 1'b0;
            bit_count_next   = bit_inc;
            if (bit_inc >= RESET_CLOCKS) begin
              phase_next     = PH_START_R;
              bit_count_next = '0;
            end
          end
        end
        PH_START_R, PH_START_M: begin
          start_idx        = (bit_count_next > 4'd6) ? START_LAST : bit_count_next[2:0];
          result.sck       = START_SCK[start_idx];
          result.data_out  = START_DAT[start_idx];
          clock_level_next = START_SCK[start_idx];
          if (start_idx == START_LAST) begin
            bit_count_next = '0;
            if (phase_next == PH_START_R) begin
              result.done_res = 1'b1;
              phase_next      = PH_IDLE;
            end else begin
              phase_next = PH_WRBIT;
            end
          end else begin
            bit_count_next = {1'b0, start_idx} + 4'd1;
          end
        end
        PH_WRBIT: begin
          result.data_out = shift_reg_next[7];
          if (!clock_level_next) begin
            result.sck       = 1'b1;
            clock_level_next = 1'b1;
          end else begin
            clock_level_next = 1'b0;
            shift_reg_next   = {shift_reg_next[6:0], 1'b0};
            bit_count_next   = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
              bit_count_next = '0;
              phase_next     = PH_WRACK;
            end
          end
        end
        PH_WRACK: begin
          if (!clock_level_next) begin
            result.sck       = 1'b1;
            clock_level_next = 1'b1;
            // No ack from the sensor: abort, next idle slot drops the clock
            if (item.data_in) begin
              result.done_res  = 1'b1;
              result.error     = 1'b1;
              clock_level_next = 1'b0;
              phase_next       = PH_IDLE;
            end
          end else begin
            clock_level_next = 1'b0;
            wait_count_next  = '0;
            phase_next       = PH_SETTLE;
          end
        end
        PH_SETTLE: begin
        end
        PH_POLL: begin
          if (!item.data_in) begin
            phase_next      = PH_RDBIT;
            bit_count_next  = '0;
            byte_count_next = '0;
            shift_reg_next  = '0;
          end else begin
            wait_count_next = wait_inc;
            if (wait_inc >= limit) begin
              result.done_res = 1'b1;
              result.error    = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
        end
        PH_RDBIT: begin
          if (!clock_level_next) begin
            result.sck       = 1'b1;
            clock_level_next = 1'b1;
            shift_reg_next   = {shift_reg_next[6:0], item.data_in};
          end else begin
            clock_level_next = 1'b0;
            bit_count_next   = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
              bit_count_next = '0;
              phase_next     = PH_RDACK;
            end
          end
        end
        PH_RDACK: begin
          result.data_out = 1'b0;
          if (!clock_level_next) begin
            result.sck       = 1'b1;
            clock_level_next = 1'b1;
          end else begin
            clock_level_next = 1'b0;
            // Store the finished byte
            case (byte_count_next)
              2'd0:    captured_word_next = {shift_reg_next, 8'd0};
              2'd1:    captured_word_next = {captured_word_next[15:8], shift_reg_next};
              default: begin
                captured_check_next = shift_reg_next;
                result.done_res     = 1'b1;
                good                = 1'b1;
              end
            endcase
            shift_reg_next = '0;
            bit_count_next = '0;
            if (good) begin
              byte_count_next = '0;
              phase_next      = PH_IDLE;
            end else begin
              byte_count_next = byte_count_next + 2'd1;
              phase_next      = PH_RDBIT;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (good) begin
        result.value    = captured_word_next;
        result.checksum = captured_check_next;
      end
    end
  end

  // Advance the link by one slot per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      byte_count     <= '0;
      shift_reg      <= '0;
      captured_word  <= '0;
      captured_check <= '0;
      wait_count     <= '0;
      clock_level    <= 1'b1;
    end else if (advance) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      byte_count     <= byte_count_next;
      shift_reg      <= shift_reg_next;
      captured_word  <= captured_word_next;
      captured_check <= captured_check_next;
      wait_count     <= wait_count_next;
      clock_level    <= clock_level_next;
    end
  end

endmodule

// ----- design/tsm_check.sv -----
// Port-level checks on the sensor master, bound to the top level.
module tsm_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        sck,
  input logic        data_out,
  input logic        busy_res,
  input logic        done_res,
  input logic        error,
  input logic [15:0] value,
  input logic [7:0]  checksum
);

  // A stalled result holds its slot
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sck) && $stable(data_out) &&
                                $stable(done_res) && $stable(value))
    else $error("result changed while stalled");

  // An error is only reported at the end of an operation
  a_error_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> done_res && busy_res)
    else $error("error without done");

  // Measurement data only appears in a clean finishing slot
  a_value_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && (value != 16'd0 || checksum != 8'd0) |-> done_res && !error)
    else $error("value outside a good end");

  // Idle slots release data and report nothing
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> data_out && !done_res)
    else $error("idle slot drives data or done");

endmodule

bind two_wire_sensor_measure_master tsm_check u_tsm_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pins_out.valid),
  .out_ready (pins_out.ready),
  .sck       (pins_out.sck),
  .data_out  (pins_out.data_out),
  .busy_res  (pins_out.busy_res),
  .done_res  (pins_out.done_res),
  .error     (pins_out.error),
  .value     (pins_out.value),
  .checksum  (pins_out.checksum)
);
